@@ rtl/core/idq_pkg.sv @@
// Package for the indexed deque with match count.
// Holds the command/result beat types, action and status codes and the cell control group.
// No dependencies.
package idq_pkg;

    // Action codes carried in the command beat
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [2:0] ACT_POP_BACK   = 3'd2;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
    localparam logic [2:0] ACT_REPLACE    = 3'd4;
    localparam logic [2:0] ACT_READ       = 3'd5;
    localparam logic [2:0] ACT_COUNT      = 3'd6;

    // Status codes carried in the result beat
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    // Bits of the match vector summed per cycle by the tally
    localparam int unsigned TALLY_GROUP = 8;

    typedef logic signed [31:0] value_t;

    // Command beat
    typedef struct packed {
        logic [2:0] action;
        logic [3:0] position;
        value_t     data_value;
    } cmd_t;

    // Result beat
    typedef struct packed {
        logic [1:0] status;
        value_t     read_value;
        logic [4:0] match_count;
        logic [4:0] fill_level;
    } result_t;

    // Control shared by every cell of the chain
    typedef struct packed {
        logic   shift_up;     // element i takes element i-1 (push front)
        logic   shift_down;   // element i takes element i+1 (pop front)
        logic   capture;      // latch per-cell match bit
        value_t value;        // load data and compare key
    } cell_ctrl_t;

endpackage

@@ rtl/core/idq_cell.sv @@
// One storage cell of the deque chain: holds element i counted from the front.
// Shifts with its neighbors, loads on demand and registers its own match bit.
// Depends on idq_pkg.
module idq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  idq_pkg::cell_ctrl_t ctrl,
    input  logic                load,
    input  logic                live,
    input  idq_pkg::value_t     up_in,
    input  idq_pkg::value_t     down_in,
    output idq_pkg::value_t     data,
    output logic                match
);
    import idq_pkg::*;

    value_t data_reg;
    logic   match_reg;

    // Element storage; no reset, a cell is only read after it is written
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= ctrl.value;
        end
        else if (ctrl.shift_up)
        begin
            data_reg <= up_in;
        end
        else if (ctrl.shift_down)
        begin
            data_reg <= down_in;
        end
    end

    // Match bit, only for cells that hold a stored element
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.capture)
        begin
            match_reg <= live && (data_reg == ctrl.value);
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

@@ rtl/core/idq_tally.sv @@
// Group-serial population count of the chain's match bits.
// Sums TALLY_GROUP bits per cycle, then pulses done with the total.
// Depends on idq_pkg.
module idq_tally #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               go,
    input  logic [CAPACITY-1:0]                match_vec,
    output logic                               done,
    output logic [$clog2(CAPACITY+1)-1:0]      count
);
    import idq_pkg::*;

    localparam int unsigned OW     = $clog2(CAPACITY + 1);
    localparam int unsigned NGROUP = (CAPACITY + TALLY_GROUP - 1) / TALLY_GROUP;
    localparam int unsigned GW     = (NGROUP > 1) ? $clog2(NGROUP) : 1;
    localparam int unsigned PADW   = NGROUP * TALLY_GROUP;
    localparam int unsigned PCW    = $clog2(TALLY_GROUP + 1);

    logic [PADW-1:0]        match_pad;
    logic [TALLY_GROUP-1:0] group_bits;
    logic [PCW-1:0]         group_sum;
    logic [OW-1:0]          acc_sum;
    logic                   last_group;

    logic            run_reg;
    logic [GW-1:0]   grp_reg;
    logic [OW-1:0]   acc_reg;
    logic            done_reg;
    logic [OW-1:0]   count_reg;

    assign match_pad  = PADW'(match_vec);
    assign group_bits = match_pad[grp_reg * TALLY_GROUP +: TALLY_GROUP];
    assign last_group = (grp_reg == GW'(NGROUP - 1));

    // Popcount of one group
    always_comb
    begin
        group_sum = '0;
        for (int i = 0; i < TALLY_GROUP; i++)
        begin
            group_sum = group_sum + PCW'(group_bits[i]);
        end
    end

    assign acc_sum = acc_reg + OW'(group_sum);

    // Walk the groups once per go
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            grp_reg  <= '0;
            acc_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                grp_reg <= '0;
                acc_reg <= '0;
            end
            else if (run_reg)
            begin
                acc_reg <= acc_sum;
                grp_reg <= grp_reg + GW'(1);
                if (last_group)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Final total, payload only
    always_ff @(posedge clk)
    begin
        if (run_reg && last_group)
        begin
            count_reg <= acc_sum;
        end
    end

    assign done  = done_reg;
    assign count = count_reg;

endmodule

@@ rtl/core/indexed_deque_with_match_count_unit.sv @@
// Top level of the indexed deque with match count: command decode, chain of cells, tally.
// Depends on idq_pkg, idq_cell and idq_tally.
//
//  channel  | handshake            | payload             | notes
//  ---------+----------------------+---------------------+---------------------------
//  command  | start / busy         | cmd    (cmd_t)      | beat taken when start & !busy
//  result   | done                 | result (result_t)   | one cycle, cannot be stalled
//
// Element i from the front always sits in cell i; pushes and pops at the front
// shift the whole chain by one cell.
// Every action but a count on a non-empty deque returns from execute to idle; the
// result strobe rises at the same edge that updates the chain.
// A count captures match bits in execute; the tally then sums 8 match bits per cycle.
// Reset empties the deque at once; cell contents are not cleared.
module indexed_deque_with_match_count_unit #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  idq_pkg::cmd_t    cmd,
    output logic             done,
    output idq_pkg::result_t result
);
    import idq_pkg::*;

    localparam int unsigned OW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = $clog2(CAPACITY);
    localparam int unsigned CW = (OW > 4) ? OW : 4;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_COUNT = 3'b100
    } state_t;

    state_t        state_reg, state_next;
    cmd_t          cmd_reg;
    logic [OW-1:0] occ_reg, occ_next;
    result_t       result_reg, result_next;
    logic          done_reg, done_next;

    cell_ctrl_t          ctrl;
    logic [CAPACITY-1:0] load_vec;
    logic [CAPACITY-1:0] live_vec;
    logic [CAPACITY-1:0] match_vec;
    value_t              cell_data [CAPACITY];

    logic          is_full, is_empty, pos_ok;
    logic [CW-1:0] pos_ext;
    logic [IW-1:0] wr_idx;
    logic          wr_en;
    logic          go_count;
    logic          tally_done;
    logic [OW-1:0] tally_count;

    assign is_full  = (occ_reg == OW'(CAPACITY));
    assign is_empty = (occ_reg == '0);
    assign pos_ext  = CW'(cmd_reg.position);
    assign pos_ok   = (pos_ext < CW'(occ_reg));

    // Cells that hold a stored element
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            live_vec[i] = (OW'(i) < occ_reg);
        end
    end

    // Action decode, active in the execute cycle
    always_comb
    begin
        ctrl.shift_up   = 1'b0;
        ctrl.shift_down = 1'b0;
        ctrl.capture    = 1'b0;
        ctrl.value      = cmd_reg.data_value;
        wr_idx          = occ_reg[IW-1:0];
        wr_en           = 1'b0;
        occ_next        = occ_reg;
        go_count        = 1'b0;
        result_next.status      = STAT_OK;
        result_next.read_value  = '0;
        result_next.match_count = '0;
        unique case (cmd_reg.action) inside
            ACT_PUSH_BACK:
            begin
                if (is_full)
                begin
                    result_next.status = STAT_FULL;
                end
                else
                begin
                    wr_en    = 1'b1;
                    occ_next = occ_reg + OW'(1);
                end
            end
            ACT_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    result_next.status = STAT_FULL;
                end
                else
                begin
                    ctrl.shift_up = 1'b1;
                    occ_next      = occ_reg + OW'(1);
                end
            end
            ACT_POP_BACK:
            begin
                if (is_empty)
                begin
                    result_next.status = STAT_EMPTY;
                end
                else
                begin
                    occ_next = occ_reg - OW'(1);
                end
            end
            ACT_POP_FRONT:
            begin
                if (is_empty)
                begin
                    result_next.status = STAT_EMPTY;
                end
                else
                begin
                    ctrl.shift_down = 1'b1;
                    occ_next        = occ_reg - OW'(1);
                end
            end
            ACT_REPLACE, ACT_READ:
            begin
                wr_idx = pos_ext[IW-1:0];
                if (is_empty)
                begin
                    result_next.status = STAT_EMPTY;
                end
                else if (!pos_ok)
                begin
                    result_next.status = STAT_RANGE;
                end
                else if (cmd_reg.action == ACT_REPLACE)
                begin
                    wr_en = 1'b1;
                end
                else
                begin
                    result_next.read_value = cell_data[pos_ext[IW-1:0]];
                end
            end
            ACT_COUNT:
            begin
                if (is_empty)
                begin
                    result_next.status = STAT_EMPTY;
                end
                else
                begin
                    ctrl.capture = 1'b1;
                    go_count     = 1'b1;
                end
            end
            default:
            begin
                // unused code: no change
            end
        endcase
        result_next.fill_level = 5'(occ_next);
        if (state_reg != S_EXEC)
        begin
            ctrl.shift_up   = 1'b0;
            ctrl.shift_down = 1'b0;
            ctrl.capture    = 1'b0;
            wr_en           = 1'b0;
            go_count        = 1'b0;
        end
    end

    // One-hot write enable down the chain
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            load_vec[i] = wr_en && (wr_idx == IW'(i));
        end
    end

    // Chain of cells, element i in cell i
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        value_t up_in;
        value_t down_in;
        if (g == 0)
        begin : g_head
            assign up_in = cmd_reg.data_value;
        end
        else
        begin : g_body
            assign up_in = cell_data[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_tail
            assign down_in = cell_data[g];
        end
        else
        begin : g_inner
            assign down_in = cell_data[g+1];
        end
        idq_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .load    (load_vec[g]),
            .live    (live_vec[g]),
            .up_in   (up_in),
            .down_in (down_in),
            .data    (cell_data[g]),
            .match   (match_vec[g])
        );
    end

    // Match tally
    idq_tally #(
        .CAPACITY (CAPACITY)
    ) u_tally (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go_count),
        .match_vec (match_vec),
        .done      (tally_done),
        .count     (tally_count)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (go_count)
                begin
                    state_next = S_COUNT;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_COUNT:
            begin
                if (tally_done)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (state_reg == S_EXEC)
            begin
                occ_reg <= occ_next;
            end
        end
    end

    // Command and result payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == S_EXEC)
        begin
            result_reg <= result_next;
        end
        else if (state_reg == S_COUNT && tally_done)
        begin
            result_reg.match_count <= 5'(tally_count);
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // Occupancy never exceeds the capacity
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OW'(CAPACITY))
        else $error("occupancy above capacity");

    // An accepted beat makes the unit busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // A result only follows work in progress
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg != S_IDLE))
        else $error("result strobe without a command in flight");

    // The tally finishes only while a count is pending
    a_tally_in_count: assert property (@(posedge clk) disable iff (!rst_n)
        tally_done |-> (state_reg == S_COUNT))
        else $error("tally done outside count");
`endif

endmodule
